// ===== src/sql_token_start_finder_assert.svh =====
// ----------------------------------------------------------------------------
// sql_token_start_finder_assert.svh
// Assertion macros used by the token start finder scanner.
// ----------------------------------------------------------------------------
`ifndef SQL_TOKEN_START_FINDER_ASSERT_SVH
`define SQL_TOKEN_START_FINDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/stf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stf_pkg
// Shared constants, types and character classes of the token start finder.
// ----------------------------------------------------------------------------
package stf_pkg;

    // Query store geometry.
    localparam int MAX_QUERY_BYTES = 4096;
    localparam int ADDR_W          = $clog2(MAX_QUERY_BYTES);
    localparam int POS_W           = $clog2(MAX_QUERY_BYTES + 1);

    // Result field widths and the packed result data bus.
    localparam int OFFSET_W   = 13;
    localparam int COUNT_W    = 13;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_PAD_W  = OUT_DATA_W - OFFSET_W - COUNT_W - 1;

    // Item operation codes.
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FETCH  = 1'b1;

    // Configuration register indexes.
    localparam int   CFG_IDX_W          = 1;
    localparam logic CFG_NO_BSLASH_ESC  = 1'b0;
    localparam logic CFG_ANSI_DQUOTE    = 1'b1;

    // Characters the scanner reacts to.
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BTICK  = 8'h60;

    // One input item.
    typedef struct packed {
        logic       op;
        logic [7:0] text_byte;
        logic       last_byte;
    } item_t;

    // Configuration registers.
    typedef struct packed {
        logic no_backslash_escape;
        logic ansi_dquote;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic [OFFSET_W-1:0] token_offset;
        logic                token_found;
        logic [COUNT_W-1:0]  token_number;
        logic                overflowed;
    } result_t;

    // Write request to the query store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } ram_wr_t;

    // Whitespace skipped ahead of a token.
    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    endfunction

    // Bytes that close a plain token.
    function automatic logic ends_token(input logic [7:0] c);
        return c inside {CH_QMARK, CH_DQUOTE, CH_SQUOTE, CH_BTICK, CH_SPACE, CH_TAB,
                         CH_CR, CH_LF, CH_DASH, CH_HASH, CH_SLASH, CH_SEMI};
    endfunction

    // Bytes that open a quoted token.
    function automatic logic is_quote(input logic [7:0] c);
        return c inside {CH_DQUOTE, CH_SQUOTE, CH_BTICK};
    endfunction

endpackage

// ===== src/stf_query_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stf_query_ram
// Query text store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module stf_query_ram import stf_pkg::*; (
    input  logic              aclk,
    input  ram_wr_t           wr,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [MAX_QUERY_BYTES];

    // Write the appended byte and read the byte the scanner needs next cycle.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/stf_scanner.sv =====
`timescale 1ns / 1ps
`include "sql_token_start_finder_assert.svh"
// ----------------------------------------------------------------------------
// stf_scanner
// Load control and byte-per-cycle token scanner over the query store.
// ----------------------------------------------------------------------------
module stf_scanner import stf_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   item,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_INSIDE = 9'b000000010,
        ST_GAP    = 9'b000000100,
        ST_DASH   = 9'b000001000,
        ST_SLASH  = 9'b000010000,
        ST_LINE   = 9'b000100000,
        ST_BLOCK  = 9'b001000000,
        ST_QUOTE  = 9'b010000000,
        ST_EMIT   = 9'b100000000
    } scan_state_t;

    scan_state_t         state_reg, state_next;
    logic [POS_W-1:0]    cur_reg, cur_next;
    logic [POS_W-1:0]    tok_reg, tok_next;
    logic [POS_W-1:0]    len_reg, len_next;
    logic [POS_W-1:0]    scan_pos_reg, scan_pos_next;
    logic                inside_reg, inside_next;
    logic                complete_reg, complete_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic [7:0]          quote_reg, quote_next;
    logic                esc_on_reg, esc_on_next;
    logic                esc_pend_reg, esc_pend_next;
    logic                star_reg, star_next;
    result_t             res_reg, res_next;

    ram_wr_t             ram_wr;
    logic [7:0]          cur_byte;
    logic [POS_W-1:0]    cur_inc;
    logic [POS_W:0]      tok_plus2;
    logic [POS_W-1:0]    eff_len;
    logic                at_end;
    logic                do_gap;
    logic                fin;
    logic                fin_found;
    logic [POS_W-1:0]    fin_off;
    logic [POS_W-1:0]    fin_scan;
    logic                fin_inside;

    stf_query_ram u_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd_addr (cur_next[ADDR_W-1:0]),
        .rd_data (cur_byte)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_EMIT);
    assign res       = res_reg;

    assign cur_inc   = cur_reg + POS_W'(1);
    assign tok_plus2 = {1'b0, tok_reg} + (POS_W + 1)'(2);
    assign at_end    = (cur_reg >= len_reg);
    assign eff_len   = complete_reg ? '0 : len_reg;

    // Next-state logic: one stored byte is examined per scanning cycle.
    always_comb begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        tok_next      = tok_reg;
        len_next      = len_reg;
        scan_pos_next = scan_pos_reg;
        inside_next   = inside_reg;
        complete_next = complete_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        quote_next    = quote_reg;
        esc_on_next   = esc_on_reg;
        esc_pend_next = esc_pend_reg;
        star_next     = star_reg;
        res_next      = res_reg;
        ram_wr        = '{en: 1'b0, addr: eff_len[ADDR_W-1:0], data: item.text_byte};
        do_gap        = 1'b0;
        fin           = 1'b0;
        fin_found     = 1'b0;
        fin_off       = '0;
        fin_scan      = scan_pos_reg;
        fin_inside    = inside_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (item.op == OP_APPEND) begin
                        // A byte after the final one starts a new text.
                        if (complete_reg) begin
                            scan_pos_next = '0;
                            inside_next   = 1'b0;
                            count_next    = '0;
                            ovf_next      = 1'b0;
                        end
                        if (eff_len < POS_W'(MAX_QUERY_BYTES)) begin
                            ram_wr.en = 1'b1;
                            len_next  = eff_len + POS_W'(1);
                        end else begin
                            len_next = eff_len;
                            ovf_next = 1'b1;
                        end
                        complete_next = item.last_byte;
                    end else if (!complete_reg || scan_pos_reg >= len_reg) begin
                        // Nothing to scan: answer at once.
                        fin = 1'b1;
                    end else begin
                        cur_next   = scan_pos_reg;
                        state_next = inside_reg ? ST_INSIDE : ST_GAP;
                    end
                end
            end

            ST_INSIDE: begin
                if (at_end) begin
                    fin      = 1'b1;
                    fin_scan = cur_reg;
                end else if (ends_token(cur_byte)) begin
                    do_gap = 1'b1;
                end else begin
                    cur_next = cur_inc;
                end
            end

            ST_GAP: begin
                if (at_end) begin
                    // Trailing whitespace or comments leave a token at the end of the text.
                    fin        = 1'b1;
                    fin_found  = 1'b1;
                    fin_off    = cur_reg;
                    fin_scan   = cur_reg;
                    fin_inside = 1'b1;
                end else begin
                    do_gap = 1'b1;
                end
            end

            ST_DASH: begin
                if (!at_end && cur_byte == CH_DASH) begin
                    state_next = ST_LINE;
                    cur_next   = cur_inc;
                end else begin
                    fin        = 1'b1;
                    fin_found  = 1'b1;
                    fin_off    = tok_reg;
                    fin_scan   = cur_reg;
                    fin_inside = 1'b1;
                end
            end

            ST_SLASH: begin
                if (!at_end && cur_byte == CH_STAR) begin
                    state_next = ST_BLOCK;
                    star_next  = 1'b0;
                    cur_next   = cur_inc;
                end else begin
                    fin        = 1'b1;
                    fin_found  = 1'b1;
                    fin_off    = tok_reg;
                    fin_scan   = cur_reg;
                    fin_inside = 1'b1;
                end
            end

            ST_LINE: begin
                if (at_end) begin
                    fin        = 1'b1;
                    fin_found  = 1'b1;
                    fin_off    = cur_reg;
                    fin_scan   = cur_reg;
                    fin_inside = 1'b1;
                end else begin
                    if (cur_byte == CH_LF) begin
                        state_next = ST_GAP;
                    end
                    cur_next = cur_inc;
                end
            end

            ST_BLOCK: begin
                if (at_end) begin
                    fin        = 1'b1;
                    fin_found  = 1'b1;
                    fin_off    = cur_reg;
                    fin_scan   = cur_reg;
                    fin_inside = 1'b1;
                end else begin
                    if (star_reg && cur_byte == CH_SLASH) begin
                        state_next = ST_GAP;
                        star_next  = 1'b0;
                    end else begin
                        star_next = (cur_byte == CH_STAR);
                    end
                    cur_next = cur_inc;
                end
            end

            ST_QUOTE: begin
                if (at_end) begin
                    // Unclosed quote: the token stays at the quote and the
                    // scan resumes two bytes after it.
                    fin        = 1'b1;
                    fin_found  = 1'b1;
                    fin_off    = tok_reg;
                    fin_inside = 1'b0;
                    fin_scan   = (tok_plus2 > {1'b0, len_reg}) ? len_reg
                                                              : tok_plus2[POS_W-1:0];
                end else if (esc_pend_reg) begin
                    esc_pend_next = 1'b0;
                    cur_next      = cur_inc;
                end else if (cur_byte == quote_reg) begin
                    fin        = 1'b1;
                    fin_found  = 1'b1;
                    fin_off    = tok_reg;
                    fin_scan   = cur_inc;
                    fin_inside = 1'b1;
                end else begin
                    esc_pend_next = esc_on_reg && (cur_byte == CH_BSLASH);
                    cur_next      = cur_inc;
                end
            end

            ST_EMIT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Classify a byte outside any token: whitespace, comment or token start.
        if (do_gap) begin
            cur_next = cur_inc;
            if (is_blank(cur_byte)) begin
                state_next = ST_GAP;
            end else if (cur_byte == CH_HASH) begin
                state_next = ST_LINE;
            end else if (cur_byte == CH_DASH) begin
                state_next = ST_DASH;
                tok_next   = cur_reg;
            end else if (cur_byte == CH_SLASH) begin
                state_next = ST_SLASH;
                tok_next   = cur_reg;
            end else if (is_quote(cur_byte)) begin
                state_next    = ST_QUOTE;
                tok_next      = cur_reg;
                quote_next    = cur_byte;
                esc_pend_next = 1'b0;
                esc_on_next   = !(cfg.no_backslash_escape || cur_byte == CH_BTICK ||
                                  (cfg.ansi_dquote && cur_byte == CH_DQUOTE));
            end else begin
                fin        = 1'b1;
                fin_found  = 1'b1;
                fin_off    = cur_reg;
                fin_scan   = cur_inc;
                fin_inside = !(cur_byte == CH_QMARK || cur_byte == CH_SEMI);
            end
        end

        // Close the fetch and stage its result.
        if (fin) begin
            state_next     = ST_EMIT;
            scan_pos_next  = fin_scan;
            inside_next    = fin_inside;
            res_next       = '{token_offset: OFFSET_W'(fin_off),
                               token_found:  fin_found,
                               token_number: count_reg,
                               overflowed:   ovf_reg};
            if (fin_found) begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            len_reg      <= '0;
            scan_pos_reg <= '0;
            inside_reg   <= 1'b0;
            complete_reg <= 1'b0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            scan_pos_reg <= scan_pos_next;
            inside_reg   <= inside_next;
            complete_reg <= complete_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
        end
    end

    // Scan cursor and per-token working registers.
    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        tok_reg      <= tok_next;
        quote_reg    <= quote_next;
        esc_on_reg   <= esc_on_next;
        esc_pend_reg <= esc_pend_next;
        star_reg     <= star_next;
        res_reg      <= res_next;
    end

    `STF_ASSERT_SAME(a_cur_in_text, aclk, aresetn,
        state_reg != ST_IDLE && state_reg != ST_EMIT, cur_reg <= len_reg,
        "scan cursor ran past the loaded text")
    `STF_ASSERT_SAME(a_scan_pos_in_text, aclk, aresetn,
        1'b1, scan_pos_reg <= len_reg && len_reg <= POS_W'(MAX_QUERY_BYTES),
        "saved scan position or text length out of range")
    `STF_ASSERT_NEXT(a_early_fetch_answers, aclk, aresetn,
        in_valid && in_ready && item.op == OP_FETCH && !complete_reg, res_valid,
        "fetch before the final byte did not answer at once")
    `STF_ASSERT_SAME(a_found_offset_in_text, aclk, aresetn,
        res_valid && res_reg.token_found, res_reg.token_offset <= OFFSET_W'(len_reg),
        "token offset lies beyond the loaded text")

endmodule

// ===== src/sql_token_start_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sql_token_start_finder
// Finds token starts in an SQL text held in an on-chip store.
// Input items: s_tuser = 0 appends s_tdata as a query byte, s_tlast marking
// the final byte; s_tuser = 1 asks for the next token start. An append is
// taken only when idle and gives no result. A byte after the final one starts
// a new text. Each fetch gives one result item: offset, ordinal, overflow
// flag in m_tdata and the found flag in m_tuser.
// A fetch that needs no scan goes straight to the scanner's result register
// and then to the output register that drives m_tvalid. Otherwise the
// scanner reads the store through its read port one byte per cycle and
// examines each byte in turn; its result then passes through the result and
// output registers. s_tready stays low until the result has moved to the
// output register, so fetches are worked one at a time.
// Reset clears length, scan state, token count and both configuration
// registers; the store itself is not cleared and needs no clearing pass.
// If the receiver stalls, the result waits in the output register while
// appends are still taken; a later fetch is scanned and then holds its
// result, with s_tready low, until that register drains.
// ----------------------------------------------------------------------------
module sql_token_start_finder import stf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic                  cfg_wdata,
    // Input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] text_byte
    input  logic                  s_tuser,   // [0] op
    input  logic                  s_tlast,   // last_byte
    // Result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [12:0] token_offset, [25:13] token_number,
                                             // [26] overflowed, rest zero
    output logic                  m_tuser    // [0] token_found
);

    cfg_t    cfg_reg, cfg_next;
    logic    m_valid_reg, m_valid_next;
    result_t m_res_reg, m_res_next;
    item_t   item;
    logic    res_valid;
    logic    res_ready;
    result_t res;

    assign item = '{op: s_tuser, text_byte: s_tdata, last_byte: s_tlast};

    stf_scanner u_scanner (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .item      (item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Configuration register writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_NO_BSLASH_ESC: cfg_next.no_backslash_escape = cfg_wdata;
                CFG_ANSI_DQUOTE:   cfg_next.ansi_dquote         = cfg_wdata;
                default:           cfg_next                     = cfg_reg;
            endcase
        end
    end

    // Output register: takes a new result whenever it is empty or draining.
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, m_res_reg.overflowed,
                       m_res_reg.token_number, m_res_reg.token_offset};
    assign m_tuser  = m_res_reg.token_found;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SQL token start finder. Query texts are loaded
// byte by byte and token starts are fetched. A cycle-free predictor follows
// every accepted item and queues the token result that each fetch should
// return. The monitor compares every result item with the oldest queued
// result, field by field. Texts cover comments, quoted strings with and
// without escapes, lone tokens and raw bytes, under every setting of the
// two quoting registers. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top import stf_pkg::*; ();

    localparam int QUIET_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 520;
    localparam int PHASES       = 8;

    // Clock, reset and DUT ports.
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic                  cfg_wdata = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = 8'h00;  // [7:0] text_byte
    logic                  s_tuser   = 1'b0;   // [0] op
    logic                  s_tlast   = 1'b0;   // last_byte
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;            // [12:0] token_offset, [25:13] token_number,
                                               // [26] overflowed, rest zero
    logic                  m_tuser;            // [0] token_found

    sql_token_start_finder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Stimulus and expectation stores.
    item_t      sql_items_todo[$];
    result_t    token_results_due[$];
    logic [7:0] text_buf[$];

    // Predictor state.
    logic [7:0]         text_mem[MAX_QUERY_BYTES];
    int                 text_len;
    int                 scan_at;
    bit                 in_token;
    bit                 text_closed;
    logic [COUNT_W-1:0] token_count;
    bit                 text_overflow;
    bit                 cfg_no_esc;
    bit                 cfg_ansi;

    // Bench control.
    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    bit  in_taken       = 1'b0;
    int  send_idle_pct  = 17;
    int  recv_idle_pct  = 17;
    bit  hold_req       = 1'b0;
    bit  hold_taken     = 1'b0;
    int  hold_left      = 0;
    int  items_queued   = 0;
    item_t   seen_item;
    result_t want;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [7:0] text_at(input int i);
        return (i < text_len) ? text_mem[i] : 8'h00;
    endfunction

    function automatic bit is_ws(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
               c == CH_FF || c == CH_CR;
    endfunction

    function automatic bit stops_token(input logic [7:0] c);
        return c == CH_QMARK || c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BTICK ||
               c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF ||
               c == CH_DASH || c == CH_HASH || c == CH_SLASH || c == CH_SEMI;
    endfunction

    // Position just past the next newline, or the end of the text.
    function automatic int skip_line(input int from);
        int i;
        for (i = from; i < text_len; i++) begin
            if (text_mem[i] == CH_LF) return i + 1;
        end
        return text_len;
    endfunction

    function automatic int skip_comment(input int p);
        logic [7:0] c;
        logic [7:0] d;
        int i;
        if (p >= text_len) return p;
        c = text_at(p);
        d = text_at(p + 1);
        if (c == CH_DASH && d == CH_DASH) return skip_line(p + 2);
        if (c == CH_HASH) return skip_line(p + 1);
        if (c == CH_SLASH && d == CH_STAR) begin
            for (i = p + 2; i + 1 < text_len; i++) begin
                if (text_mem[i] == CH_STAR && text_mem[i + 1] == CH_SLASH) return i + 2;
            end
            return text_len;
        end
        return p;
    endfunction

    // Skip any mix of comments and whitespace ahead of a token.
    function automatic int skip_gap(input int p);
        bit first;
        int prev;
        first = 1'b1;
        prev  = 0;
        while (p < text_len && (first || p != prev)) begin
            first = 1'b0;
            prev  = p;
            p = skip_comment(p);
            while (p < text_len && is_ws(text_mem[p])) p++;
        end
        return p;
    endfunction

    function automatic int skip_quoted(input int p, input logic [7:0] q, input bit esc);
        while (p < text_len && text_mem[p] != q) begin
            if (esc && text_mem[p] == CH_BSLASH) begin
                p++;
                if (p >= text_len) break;
            end
            p++;
        end
        return p;
    endfunction

    // Apply one accepted item; a fetch queues the token result it must return.
    task automatic find_next_token(input item_t it);
        result_t    r;
        int         p;
        int         off;
        int         resume;
        logic [7:0] c;
        bit         esc;
        bit         got;
        if (it.op == OP_APPEND) begin
            // A byte after the final one starts a fresh text.
            if (text_closed) begin
                text_len      = 0;
                scan_at       = 0;
                in_token      = 1'b0;
                text_closed   = 1'b0;
                token_count   = '0;
                text_overflow = 1'b0;
            end
            if (text_len < MAX_QUERY_BYTES) begin
                text_mem[text_len] = it.text_byte;
                text_len++;
            end else begin
                text_overflow = 1'b1;
            end
            if (it.last_byte) text_closed = 1'b1;
        end else begin
            r.token_offset = '0;
            r.token_found  = 1'b0;
            r.token_number = token_count;
            r.overflowed   = text_overflow;
            if (text_closed) begin
                p   = scan_at;
                got = 1'b0;
                while (p < text_len && !got) begin
                    if (in_token) begin
                        // Run to the end of the current plain token.
                        if (stops_token(text_mem[p])) in_token = 1'b0;
                        else p++;
                    end else begin
                        p        = skip_gap(p);
                        off      = p;
                        in_token = 1'b1;
                        c        = text_at(p);
                        if (p < text_len &&
                            (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BTICK)) begin
                            resume = p + 1;
                            esc = !(cfg_no_esc || c == CH_BTICK || (cfg_ansi && c == CH_DQUOTE));
                            p = skip_quoted(resume, c, esc);
                            // An unclosed quote: resume two bytes after it.
                            if (p >= text_len) begin
                                p        = resume;
                                in_token = 1'b0;
                            end
                        end else if (c == CH_QMARK || c == CH_SEMI) begin
                            in_token = 1'b0;
                        end
                        p++;
                        if (p > text_len) p = text_len;
                        r.token_offset = off[OFFSET_W-1:0];
                        r.token_found  = 1'b1;
                        r.token_number = token_count;
                        token_count    = token_count + COUNT_W'(1);
                        got            = 1'b1;
                    end
                end
                scan_at = p;
            end
            token_results_due.insert(token_results_due.size(), r);
        end
    endtask

    task automatic flag_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    // ------------------------------------------------------------------
    // Prediction, result checking and watchdog at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            in_taken = s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                if (token_results_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual %h/%b",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = token_results_due.pop_front();
                    flag_field("token_offset", int'(want.token_offset),
                               int'(m_tdata[OFFSET_W-1:0]));
                    flag_field("token_number", int'(want.token_number),
                               int'(m_tdata[OFFSET_W+COUNT_W-1:OFFSET_W]));
                    flag_field("overflowed", int'(want.overflowed),
                               int'(m_tdata[OFFSET_W+COUNT_W]));
                    flag_field("token_found", int'(want.token_found), int'(m_tuser));
                    flag_field("tdata padding", 0,
                               int'(m_tdata[OUT_DATA_W-1:OFFSET_W+COUNT_W+1]));
                end
            end
            if (in_taken) begin
                seen_item.op        = s_tuser;
                seen_item.text_byte = s_tdata;
                seen_item.last_byte = s_tlast;
                find_next_token(seen_item);
            end
            if (in_taken || (m_tvalid && m_tready) || cfg_wr_en) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end else begin
            in_taken = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Input driver: offers queued items, idling at random.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (sql_items_todo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                seen_item = sql_items_todo.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= seen_item.op;
                s_tdata  <= seen_item.text_byte;
                s_tlast  <= seen_item.last_byte;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls plus one long hold-off on request.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic put_byte(input logic [7:0] b);
        text_buf.insert(text_buf.size(), b);
    endtask

    task automatic put_item(input item_t it);
        sql_items_todo.insert(sql_items_todo.size(), it);
        items_queued++;
    endtask

    task automatic add_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic add_letters(input int n);
        repeat (n) put_byte(8'h61 + 8'($urandom_range(0, 25)));
    endtask

    task automatic push_fetch();
        item_t it;
        it.op        = OP_FETCH;
        it.text_byte = 8'($urandom_range(0, 255));
        it.last_byte = 1'($urandom_range(0, 1));
        put_item(it);
    endtask

    // Queue the text in text_buf as appends, optionally with a fetch in the
    // middle of the load, followed by a number of fetches.
    task automatic queue_text(input int n_fetch, input bit early);
        item_t it;
        int    mid;
        int    i;
        mid = early ? int'($urandom_range(0, text_buf.size() - 1)) : -1;
        for (i = 0; i < text_buf.size(); i++) begin
            if (i == mid) push_fetch();
            it.op        = OP_APPEND;
            it.text_byte = text_buf[i];
            it.last_byte = (i == text_buf.size() - 1);
            put_item(it);
        end
        repeat (n_fetch) push_fetch();
        text_buf.delete();
    endtask

    // One random piece of SQL text, mostly well formed.
    task automatic add_fragment();
        logic [7:0] q;
        int         n;
        case ($urandom_range(0, 15))
            0, 1, 2: add_letters($urandom_range(1, 6));
            3: begin
                case ($urandom_range(0, 5))
                    0: put_byte(CH_SPACE);
                    1: put_byte(CH_TAB);
                    2: put_byte(CH_LF);
                    3: put_byte(CH_VT);
                    4: put_byte(CH_FF);
                    default: put_byte(CH_CR);
                endcase
            end
            4: put_byte(CH_SPACE);
            5: begin
                add_str("--");
                add_letters($urandom_range(0, 4));
                if ($urandom_range(0, 4) != 0) put_byte(CH_LF);
            end
            6: begin
                put_byte(CH_HASH);
                add_letters($urandom_range(0, 4));
                if ($urandom_range(0, 4) != 0) put_byte(CH_LF);
            end
            7: begin
                add_str("/*");
                n = $urandom_range(0, 4);
                repeat (n) begin
                    if ($urandom_range(0, 2) == 0) put_byte(CH_STAR);
                    else add_letters(1);
                end
                if ($urandom_range(0, 5) != 0) add_str("*/");
            end
            8, 9: begin
                // Quoted string with escapes, other quotes and loose backslashes.
                case ($urandom_range(0, 2))
                    0: q = CH_SQUOTE;
                    1: q = CH_DQUOTE;
                    default: q = CH_BTICK;
                endcase
                put_byte(q);
                n = $urandom_range(0, 5);
                repeat (n) begin
                    case ($urandom_range(0, 4))
                        0, 1: add_letters(1);
                        2: begin
                            put_byte(CH_BSLASH);
                            put_byte(q);
                        end
                        3: put_byte(CH_BSLASH);
                        default: put_byte($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
                    endcase
                end
                if ($urandom_range(0, 7) != 0) put_byte(q);
            end
            10: put_byte(CH_QMARK);
            11: put_byte(CH_SEMI);
            12: put_byte($urandom_range(0, 1) ? CH_DASH : CH_SLASH);
            13: put_byte(8'($urandom_range(0, 255)));
            14: put_byte($urandom_range(0, 1) ? CH_BSLASH : CH_STAR);
            default: put_byte($urandom_range(0, 1) ? CH_BTICK : CH_SQUOTE);
        endcase
    endtask

    // Wait until every item is taken and every result has come back.
    task automatic drain();
        while (sql_items_todo.size() != 0 || s_tvalid || token_results_due.size() != 0)
            @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        if (idx == CFG_NO_BSLASH_ESC) cfg_no_esc = v;
        else cfg_ansi = v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int ph;
        int phase_start;
        int nfrag;

        text_len      = 0;
        scan_at       = 0;
        in_token      = 1'b0;
        text_closed   = 1'b0;
        token_count   = '0;
        text_overflow = 1'b0;
        cfg_no_esc    = 1'b0;
        cfg_ansi      = 1'b0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: a fetch before any text is loaded.
        push_fetch();

        // Escaped double quote, hash comment, lone ? and ;, fetch mid-load.
        put_byte(CH_DQUOTE);
        add_str("a");
        put_byte(CH_BSLASH);
        put_byte(CH_DQUOTE);
        add_str("b");
        put_byte(CH_DQUOTE);
        put_byte(CH_HASH);
        put_byte(CH_LF);
        put_byte(CH_QMARK);
        put_byte(CH_SEMI);
        queue_text(4, 1'b1);

        // Byte extremes, an unclosed quote and a trailing unclosed comment.
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(CH_SPACE);
        put_byte(CH_SQUOTE);
        add_str("u");
        put_byte(CH_SLASH);
        put_byte(CH_STAR);
        queue_text(4, 1'b0);
        drain();

        // Random phases, walking through every register setting.
        items_queued = 0;
        for (ph = 0; ph < PHASES; ph++) begin
            write_cfg(CFG_NO_BSLASH_ESC, ph[0]);
            write_cfg(CFG_ANSI_DQUOTE, ph[1]);
            send_idle_pct = (ph == 1) ? 0 : 17;
            recv_idle_pct = (ph == 1) ? 0 : 17;
            if (ph == 2) hold_req = 1'b1;
            phase_start = items_queued;

            while (items_queued - phase_start < RANDOM_ITEMS / PHASES) begin
                nfrag = $urandom_range(1, 10);
                if ($urandom_range(0, 7) == 0) begin
                    repeat (nfrag) put_byte(8'($urandom_range(0, 255)));
                end else begin
                    repeat (nfrag) add_fragment();
                end
                queue_text(int'($urandom_range(1, nfrag + 2)), $urandom_range(0, 9) == 0);
            end
            drain();
        end

        repeat (50) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sql_token_start_finder.f =====
+incdir+src
src/stf_pkg.sv
src/stf_query_ram.sv
src/stf_scanner.sv
src/sql_token_start_finder.sv
tb/tb_top.sv
